FILE: hdl/fspa_pkg.sv
package fspa_pkg;

	localparam int SLOT_W   = 10;
	localparam int OFFSET_W = 22;
	localparam int LIMIT_W  = 11;
	localparam int BYTES_W  = 13;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 16;

	localparam logic KIND_ALLOC = 1'b0;
	localparam logic KIND_FREE  = 1'b1;

	localparam logic [1:0] ST_ALLOC     = 2'd0;
	localparam logic [1:0] ST_EXHAUSTED = 2'd1;
	localparam logic [1:0] ST_FREED     = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_SLOTS_IN_USE = 4'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SLOT_BYTES   = 4'd1;

	localparam logic [LIMIT_W-1:0] RST_SLOTS_IN_USE = 11'd1024;
	localparam logic [BYTES_W-1:0] RST_SLOT_BYTES   = 13'd16;

	typedef struct packed {
		logic              kind;
		logic [SLOT_W-1:0] slot;
	} req_t;

	typedef struct packed {
		logic [SLOT_W-1:0]   granted_slot;
		logic [OFFSET_W-1:0] byte_offset;
		logic [1:0]          status;
	} result_t;

	// link held for one free list entry
	typedef struct packed {
		logic              valid;
		logic [SLOT_W-1:0] slot;
	} link_t;

	typedef struct packed {
		logic [LIMIT_W-1:0] slots_in_use;
		logic [BYTES_W-1:0] slot_bytes;
	} cfg_t;

endpackage

FILE: hdl/fixed_slot_pool_allocator.sv
// channel  | handshake           | word
// request  | start / busy        | req      (kind, slot)
// result   | done (one cycle)    | result   (granted_slot, byte_offset, status)
// config   | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// one request per cycle; busy stays low, so a request may start in every cycle
// the result is registered: it appears in the cycle after its request, with done high in that cycle
// the link of the head slot is held in a register; a pop reloads it from the
// link memory, whose read address follows the cached link every cycle
// arst_n clears the free list, bump counter and config to their reset values
// the result side cannot stall; cfg_ready is always high
module fixed_slot_pool_allocator
	import fspa_pkg::*;
#(
	parameter int POOL_SLOTS = 1024
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  req_t                  req,
	output logic                  done,
	output result_t               result,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int DEPTH = (POOL_SLOTS < 1024) ? POOL_SLOTS : 1024;
	localparam int AW    = $clog2(DEPTH);
	localparam logic [LIMIT_W-1:0] BUMP_MAX = LIMIT_W'(DEPTH);

	cfg_t cfg;

	logic [SLOT_W-1:0]  head_q;
	logic               nonempty_q;
	link_t              link_q;
	logic               pending_q;
	logic [LIMIT_W-1:0] bump_q;
	logic               done_q;
	result_t            result_q;

	link_t              rd_link;
	link_t              eff_link;
	logic [LIMIT_W-1:0] bump_limit;
	logic               accept;
	logic               is_free;
	logic               in_pool;
	logic               pop;
	logic               bump;
	logic               push;
	logic [SLOT_W-1:0]  grant;
	logic [1:0]         status;
	logic [SLOT_W+BYTES_W-1:0] prod;

	fspa_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	fspa_link_ram #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_link_ram (
		.clk   (clk),
		.we    (push),
		.waddr (req.slot[AW-1:0]),
		.wdata ({nonempty_q, head_q}),
		.raddr (eff_link.slot[AW-1:0]),
		.rdata (rd_link)
	);

	assign busy     = 1'b0;
	assign accept   = start && !busy;
	assign is_free  = (req.kind == KIND_FREE);
	assign in_pool  = (int'(req.slot) < DEPTH);
	assign eff_link = pending_q ? rd_link : link_q;

	assign bump_limit = (cfg.slots_in_use < BUMP_MAX) ? cfg.slots_in_use : BUMP_MAX;

	assign push = accept && is_free && in_pool;
	assign pop  = accept && !is_free && nonempty_q;
	assign bump = accept && !is_free && !nonempty_q && (bump_q < bump_limit);

	always_comb begin
		grant  = '0;
		status = ST_EXHAUSTED;
		if (is_free) begin
			status = ST_FREED;
		end else if (pop) begin
			grant  = head_q;
			status = ST_ALLOC;
		end else if (bump) begin
			grant  = bump_q[SLOT_W-1:0];
			status = ST_ALLOC;
		end
	end

	assign prod = {{BYTES_W{1'b0}}, grant} * {{SLOT_W{1'b0}}, cfg.slot_bytes};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q     <= '0;
			nonempty_q <= 1'b0;
			link_q     <= '0;
			pending_q  <= 1'b0;
			bump_q     <= '0;
			done_q     <= 1'b0;
		end else begin
			done_q <= accept;
			if (push) begin
				head_q     <= req.slot;
				nonempty_q <= 1'b1;
				link_q     <= {nonempty_q, head_q};
				pending_q  <= 1'b0;
			end else if (pop) begin
				head_q     <= eff_link.slot;
				nonempty_q <= eff_link.valid;
				pending_q  <= 1'b1;
			end else begin
				link_q    <= eff_link;
				pending_q <= 1'b0;
			end
			if (bump) begin
				bump_q <= bump_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			result_q.granted_slot <= grant;
			result_q.byte_offset  <= (status == ST_ALLOC) ? prod[OFFSET_W-1:0] : '0;
			result_q.status       <= status;
		end
	end

	assign done   = done_q;
	assign result = result_q;

`ifndef SYNTHESIS
	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> done)
		else $error("request without result");

	a_no_extra_done: assert property (@(posedge clk) disable iff (!arst_n)
		!accept |=> !done)
		else $error("result without request");

	a_bump_bound: assert property (@(posedge clk) disable iff (!arst_n)
		bump_q <= BUMP_MAX)
		else $error("bump counter beyond pool");

	a_pop_reload: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> pending_q)
		else $error("head link not reloaded after pop");

	a_quiet_fields: assert property (@(posedge clk) disable iff (!arst_n)
		done && (result.status != ST_ALLOC) |->
			(result.granted_slot == '0) && (result.byte_offset == '0))
		else $error("nonzero fields on non-grant result");
`endif

endmodule

FILE: hdl/fspa_link_ram.sv
module fspa_link_ram
	import fspa_pkg::*;
#(
	parameter int DEPTH = 1024,
	parameter int AW    = 10
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  link_t         wdata,
	input  logic [AW-1:0] raddr,
	output link_t         rdata
);

	link_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: hdl/fspa_cfg.sv
module fspa_cfg
	import fspa_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.slots_in_use <= RST_SLOTS_IN_USE;
			cfg_q.slot_bytes   <= RST_SLOT_BYTES;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_SLOTS_IN_USE: cfg_q.slots_in_use <= cfg_data[LIMIT_W-1:0];
				CFG_SLOT_BYTES:   cfg_q.slot_bytes   <= cfg_data[BYTES_W-1:0];
				default: ;
			endcase
		end
	end

endmodule
